FILE: src/hall_sector_angle_speed_estimator_top_defines.svh
// Assertion macros for the Hall sector angle and speed estimator.
`ifndef HALL_SECTOR_ANGLE_SPEED_ESTIMATOR_TOP_DEFINES_SVH
`define HALL_SECTOR_ANGLE_SPEED_ESTIMATOR_TOP_DEFINES_SVH
// Implication checked every clock, off during reset.
`define HSE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, off during reset.
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/hsase_pkg.sv
// Package: constants, tables and types of the Hall sector estimator.
package hsase_pkg;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = 24 + FILL_W;

    localparam logic [1:0] FUNC_EDGE = 2'd0;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [2:0] REG_PHASE = 3'd0;
    localparam logic [2:0] REG_MOUNT = 3'd1;
    localparam logic [2:0] REG_SPAN = 3'd2;
    localparam logic [2:0] REG_TPP = 3'd3;
    localparam logic [2:0] REG_ERPM = 3'd4;
    localparam logic [2:0] REG_POLES = 3'd5;

    localparam logic [15:0] SNAP_STEP_LIMIT = 16'd10;

    // divider operation select
    localparam logic [1:0] DIV_AVG = 2'd0;
    localparam logic [1:0] DIV_STEP = 2'd1;
    localparam logic [1:0] DIV_RPM = 2'd2;
    localparam logic [1:0] DIV_MECH = 2'd3;

    typedef struct packed {
        logic [15:0] phase;
        logic [15:0] mount;
        logic [14:0] span;
        logic [15:0] tpp;
        logic [30:0] erpm;
        logic [6:0] poles;
    } cfg_t;

    typedef struct packed {
        logic load_in;   // capture input beat
        logic event_a;   // immediate event handling (step, dir, err, fifo push)
        logic div_start;
        logic [1:0] div_sel;
        logic div_take; // write divider result to selected target
        logic speed_fin; // apply clamp and sign
        logic finish;    // boundary / progress and angle rebuild
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic push;      // edge pushed a sample
    } sts_t;

    function automatic logic [2:0] step_of_code(input logic [2:0] c);
        case (c)
            3'd1: step_of_code = 3'd6;
            3'd2: step_of_code = 3'd2;
            3'd3: step_of_code = 3'd1;
            3'd4: step_of_code = 3'd4;
            3'd5: step_of_code = 3'd5;
            3'd6: step_of_code = 3'd3;
            default: step_of_code = 3'd0;
        endcase
    endfunction

    function automatic logic [15:0] enter_cw(input logic [2:0] c);
        case (c)
            3'd1: enter_cw = 16'd24357;
            3'd2: enter_cw = 16'd46616;
            3'd3: enter_cw = 16'd33437;
            3'd4: enter_cw = 16'd2535;
            3'd5: enter_cw = 16'd11956;
            3'd6: enter_cw = 16'd55191;
            default: enter_cw = 16'd0;
        endcase
    endfunction

    function automatic logic [15:0] enter_ccw(input logic [2:0] c);
        case (c)
            3'd1: enter_ccw = 16'd30629;
            3'd2: enter_ccw = 16'd52296;
            3'd3: enter_ccw = 16'd43170;
            3'd4: enter_ccw = 16'd8718;
            3'd5: enter_ccw = 16'd21077;
            3'd6: enter_ccw = 16'd65216;
            default: enter_ccw = 16'd0;
        endcase
    endfunction

    function automatic logic [15:0] centre_of(input logic [2:0] c);
        case (c)
            3'd1: centre_of = 16'd27493;
            3'd2: centre_of = 16'd49456;
            3'd3: centre_of = 16'd38303;
            3'd4: centre_of = 16'd5626;
            3'd5: centre_of = 16'd16516;
            3'd6: centre_of = 16'd60167;
            default: centre_of = 16'd0;
        endcase
    endfunction
endpackage

FILE: src/hsase_div.sv
// Radix-2 restoring divider, 32-bit dividend and divisor, one bit per cycle.
module hsase_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: src/hsase_datapath.sv
// Datapath: event state, period FIFO, speed math and angle registers.
module hsase_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  hsase_pkg::cfg_t     cfg,
    input  hsase_pkg::cmd_t     cmd,
    output hsase_pkg::sts_t     sts,
    input  logic [31:0]         in_data,
    output logic [151:0]        out_data
);
    import hsase_pkg::*;

    logic [1:0]  func_reg;
    logic [2:0]  code_reg;
    logic [23:0] per_reg;
    logic pos_reg, pos_next;
    logic spd_reg, spd_next;
    logic [1:0] dir_reg, dir_next; // 0 unknown, 1 cw, 2 ccw
    logic [2:0] step_reg, step_next;
    logic [7:0] err_reg, err_next;
    logic flt_reg, flt_next;
    logic [23:0] fifo_reg [FIFO_DEPTH];
    logic [SUM_W-1:0] sum_reg;
    logic [FIFO_AW-1:0] idx_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [23:0] avg_reg;
    logic [31:0] q_reg;      // raw step quotient
    logic [15:0] spp_reg;
    logic [31:0] mag_reg, mmag_reg;
    logic [31:0] erpm_reg, mrpm_reg;
    logic [15:0] bnd_reg, prog_reg;
    logic push_reg;
    logic clr;
    logic tick_sync_reg;
    logic upd;

    logic [2:0] nstep;
    logic ccw;
    logic [2:0] pfwd, pbwd;
    logic [31:0] div_a, div_b, div_q;
    logic div_done;
    logic [6:0] pp;
    logic [16:0] nxt;
    logic [15:0] a0, a1, bnd_new;

    assign nstep = step_of_code(code_reg);
    assign ccw = (dir_reg == 2'd2);
    assign pfwd = (step_reg == 3'd6) ? 3'd1 : step_reg + 3'd1;
    assign pbwd = (nstep == 3'd6) ? 3'd1 : nstep + 3'd1;
    assign pp = (cfg.poles == 7'd0) ? 7'd1 : cfg.poles;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_AVG:  begin div_a = {{(32-SUM_W){1'b0}}, sum_reg};
                            div_b = {{(32-FILL_W){1'b0}}, fill_reg}; end
            DIV_STEP: begin div_a = 32'(cfg.span) * 32'(cfg.tpp);
                            div_b = {8'd0, avg_reg}; end
            DIV_RPM:  begin div_a = {1'b0, cfg.erpm}; div_b = {8'd0, avg_reg}; end
            default:  begin div_a = mag_reg; div_b = {25'd0, pp}; end
        endcase
    end

    hsase_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    assign sts.div_done = div_done;
    assign sts.push = push_reg;

    // event decode
    always_comb
    begin
        pos_next = pos_reg;
        spd_next = spd_reg;
        dir_next = dir_reg;
        step_next = step_reg;
        err_next = err_reg;
        flt_next = flt_reg;
        clr = 1'b0;
        unique case (func_reg)
            FUNC_EDGE:
            begin
                if (nstep == 3'd0)
                begin
                    pos_next = 1'b0;
                    if (err_reg != 8'hFF)
                        err_next = err_reg + 8'd1;
                    clr = 1'b1;
                    if (err_next >= 8'd3)
                        flt_next = 1'b1;
                end
                else
                begin
                    if (!pos_reg)
                        dir_next = ccw ? 2'd2 : 2'd1;
                    else if (step_reg != 3'd0 && step_reg != nstep && pfwd == nstep)
                        dir_next = 2'd1;
                    else if (step_reg != 3'd0 && step_reg != nstep && pbwd == step_reg)
                        dir_next = 2'd2;
                    else if (err_reg != 8'hFF)
                        err_next = err_reg + 8'd1;
                    step_next = nstep;
                    pos_next = 1'b1;
                    if (per_reg != 24'd0)
                        spd_next = 1'b1;
                end
            end
            FUNC_TIMEOUT: clr = 1'b1;
            FUNC_TICK:
            begin
                if (!pos_reg && nstep != 3'd0)
                begin
                    step_next = nstep;
                    dir_next = ccw ? 2'd2 : 2'd1;
                    pos_next = 1'b1;
                end
            end
            default: ;
        endcase
        if (clr)
            spd_next = 1'b0;
    end

    assign nxt = {1'b0, prog_reg} + {1'b0, spp_reg};
    assign bnd_new = (!spd_reg || spp_reg <= SNAP_STEP_LIMIT) ? centre_of(code_reg)
                   : (ccw ? enter_ccw(code_reg) : enter_cw(code_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 1'b0;
            spd_reg <= 1'b0;
            dir_reg <= 2'd0;
            step_reg <= 3'd0;
            err_reg <= 8'd0;
            flt_reg <= 1'b0;
            sum_reg <= '0;
            idx_reg <= '0;
            fill_reg <= '0;
            avg_reg <= '0;
            q_reg <= '0;
            mag_reg <= '0;
            mmag_reg <= '0;
            spp_reg <= '0;
            erpm_reg <= '0;
            mrpm_reg <= '0;
            bnd_reg <= '0;
            prog_reg <= '0;
            push_reg <= 1'b0;
            for (int i = 0; i < FIFO_DEPTH; i++)
                fifo_reg[i] <= '0;
        end
        else
        begin
            if (cmd.event_a)
            begin
                pos_reg <= pos_next;
                spd_reg <= spd_next;
                dir_reg <= dir_next;
                step_reg <= step_next;
                err_reg <= err_next;
                flt_reg <= flt_next;
                push_reg <= 1'b0;
                if (clr)
                begin
                    spp_reg <= '0;
                    erpm_reg <= '0;
                    mrpm_reg <= '0;
                    sum_reg <= '0;
                    idx_reg <= '0;
                    fill_reg <= '0;
                    avg_reg <= '0;
                    for (int i = 0; i < FIFO_DEPTH; i++)
                        fifo_reg[i] <= '0;
                end
                else if (func_reg == FUNC_EDGE && per_reg != 24'd0)
                begin
                    push_reg <= 1'b1;
                    if (fill_reg < FILL_W'(FIFO_DEPTH))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        sum_reg <= sum_reg + SUM_W'(per_reg);
                    end
                    else
                        sum_reg <= sum_reg - SUM_W'(fifo_reg[idx_reg]) + SUM_W'(per_reg);
                    fifo_reg[idx_reg] <= per_reg;
                    idx_reg <= (32'(idx_reg) == FIFO_DEPTH - 1) ? '0 : idx_reg + 1'b1;
                end
            end
            if (cmd.div_take)
            begin
                case (cmd.div_sel)
                    DIV_AVG:  avg_reg <= div_q[23:0];
                    DIV_STEP: q_reg <= div_q;
                    DIV_RPM:  mag_reg <= div_q;
                    default:  mmag_reg <= div_q;
                endcase
            end
            if (cmd.speed_fin)
            begin
                if (avg_reg == 24'd0)
                begin
                    spp_reg <= '0;
                    erpm_reg <= '0;
                    mrpm_reg <= '0;
                end
                else
                begin
                    spp_reg <= (q_reg > {17'd0, cfg.span}) ? {1'b0, cfg.span} : q_reg[15:0];
                    erpm_reg <= ccw ? mag_reg : 32'd0 - mag_reg;
                    mrpm_reg <= ccw ? mmag_reg : 32'd0 - mmag_reg;
                end
            end
            if (cmd.finish)
            begin
                if (func_reg == FUNC_EDGE && step_of_code(code_reg) != 3'd0)
                begin
                    bnd_reg <= bnd_new;
                    prog_reg <= '0;
                end
                else if (func_reg == FUNC_TICK)
                begin
                    if (tick_sync_reg)
                    begin
                        bnd_reg <= bnd_new;
                        prog_reg <= '0;
                    end
                    else if (spd_reg && spp_reg != 16'd0)
                        prog_reg <= (nxt >= {2'b0, cfg.span}) ? {1'b0, cfg.span} : nxt[15:0];
                end
            end
        end
    end

    // tick sync flag captured at event stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_sync_reg <= 1'b0;
        else if (cmd.event_a)
            tick_sync_reg <= (func_reg == FUNC_TICK) && !pos_reg && (nstep != 3'd0);
    end

    // angle for the finish step: rebuild uses the boundary and progress being written
    logic [15:0] bsel, psel;
    assign upd = (func_reg == FUNC_EDGE && nstep != 3'd0) || tick_sync_reg;
    always_comb
    begin
        bsel = upd ? bnd_new : bnd_reg;
        if (upd)
            psel = 16'd0;
        else if (func_reg == FUNC_TICK && pos_reg && spd_reg && spp_reg != 16'd0)
            psel = (nxt >= {2'b0, cfg.span}) ? {1'b0, cfg.span} : nxt[15:0];
        else
            psel = prog_reg;
        a0 = ccw ? bsel - psel : bsel + psel;
        a1 = a0 + cfg.phase;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_data[1:0];
            code_reg <= in_data[4:2];
            per_reg <= in_data[28:5];
        end
    end

    // the angle registers only change on rebuilds; others keep the old value
    logic rebuild_en;
    assign rebuild_en = (func_reg == FUNC_EDGE && nstep != 3'd0) || func_reg == FUNC_TICK && pos_reg
                        || tick_sync_reg;

    logic [15:0] aout_q, araw_q;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aout_q <= '0;
            araw_q <= '0;
        end
        else if (cmd.finish && rebuild_en)
        begin
            aout_q <= a1 + cfg.mount;
            araw_q <= a1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data <= {5'd0, err_reg, flt_reg, pos_reg, spd_reg, ccw,
                         avg_reg, spp_reg[14:0], mrpm_reg, erpm_reg, araw_q, aout_q};
    end
endmodule

FILE: src/hsase_ctrl.sv
// Controller: sequences capture, event update, divisions and angle rebuild.
module hsase_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  hsase_pkg::sts_t sts,
    output hsase_pkg::cmd_t cmd
);
    import hsase_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVT = 4'd1;
    localparam logic [3:0] S_CHK = 4'd2;
    localparam logic [3:0] S_DIV = 4'd3;
    localparam logic [3:0] S_SPD = 4'd4;
    localparam logic [3:0] S_FIN = 4'd5;
    localparam logic [3:0] S_OUT = 4'd6;
    localparam logic [3:0] S_HOLD = 4'd7;

    logic [3:0] st_reg, st_next;
    logic [1:0] sel_reg, sel_next;
    logic ov_reg, ov_next;
    logic go;

    assign s_ready = (st_reg == S_IDLE);
    assign go = s_valid && s_ready;
    assign m_valid = ov_reg;

    always_comb
    begin
        st_next = st_reg;
        sel_next = sel_reg;
        ov_next = ov_reg && !m_ready;
        cmd = '0;
        cmd.div_sel = sel_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                cmd.load_in = go;
                if (go)
                    st_next = S_EVT;
            end
            S_EVT:
            begin
                cmd.event_a = 1'b1;
                st_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.push)
                begin
                    sel_next = DIV_AVG;
                    cmd.div_sel = DIV_AVG;
                    cmd.div_start = 1'b1;
                    st_next = S_DIV;
                end
                else
                    st_next = S_FIN;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    if (sel_reg == DIV_MECH)
                        st_next = S_SPD;
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                        st_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                cmd.div_start = 1'b1;
                st_next = S_DIV;
            end
            S_SPD:
            begin
                cmd.speed_fin = 1'b1;
                st_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            sel_reg <= DIV_AVG;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            sel_reg <= sel_next;
            ov_reg <= ov_next;
        end
    end
endmodule

FILE: src/hall_sector_angle_speed_estimator_top.sv
// Hall sector angle and speed estimator: one result beat per input beat. A Hall edge
// with a valid code and a nonzero period runs four divisions in one shared radix-2
// divider (average, angle step, electrical and mechanical rpm). One beat is in work at
// a time; the result sits in an output register while the next input beat is taken.
module hall_sector_angle_speed_estimator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,  // func[1:0], hall_code[4:2], hall_period[28:5]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,  // elec_angle, angle_before_mount, elec_rpm, mech_rpm,
                                   // angle_step, period_average, direction_ccw,
                                   // speed_ok, position_ok, fault_flag, error_total
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data
);
    import hsase_pkg::*;
`include "hall_sector_angle_speed_estimator_top_defines.svh"

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase <= 16'd0;
            cfg_reg.mount <= 16'd32768;
            cfg_reg.span <= 15'd10923;
            cfg_reg.tpp <= 16'd6000;
            cfg_reg.erpm <= 31'd960000000;
            cfg_reg.poles <= 7'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE: cfg_reg.phase <= cfg_data[15:0];
                REG_MOUNT: cfg_reg.mount <= cfg_data[15:0];
                REG_SPAN:  cfg_reg.span <= cfg_data[14:0];
                REG_TPP:   cfg_reg.tpp <= cfg_data[15:0];
                REG_ERPM:  cfg_reg.erpm <= cfg_data;
                REG_POLES: cfg_reg.poles <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    hsase_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready), .sts(sts), .cmd(cmd)
    );

    hsase_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .cmd(cmd), .sts(sts),
        .in_data(s_tdata), .out_data(m_tdata)
    );

    `HSE_ASSERT_IMPL(a_ready_excl, s_tready && cmd.finish, 1'b0, "ready during work")
    `HSE_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "ready after accept")
    `HSE_ASSERT_NEXT(a_out_set, cmd.out_load, m_tvalid, "result not shown")
endmodule

FILE: verif/tb_top.sv
// Testbench for the Hall sector angle and speed estimator: predicts and checks every result beat.
`timescale 1ns / 1ps

class hall_scoreboard;
    logic [146:0] pending_results[$];
    int unsigned  mismatches;

    // configuration copy
    logic [15:0] phase_ofs, mount_ofs;
    logic [14:0] span;
    logic [15:0] tpp;
    logic [30:0] erpm_k;
    logic [6:0]  poles;

    // estimator state
    bit          pos_ok, spd_ok, fault;
    logic [1:0]  dir;      // 0 unknown, 1 CW, 2 CCW
    logic [2:0]  cur_step;
    logic [7:0]  errs;
    logic [23:0] samples[8];
    logic [26:0] sample_sum;
    int unsigned wr_ptr, fill;
    logic [23:0] avg;
    logic [15:0] step_pwm;
    logic [31:0] erpm, mrpm;
    logic [15:0] bound, progress, angle_out, angle_raw;

    function new();
        phase_ofs = 0; mount_ofs = 16'd32768; span = 15'd10923; tpp = 16'd6000;
        erpm_k = 31'd960000000; poles = 7'd4;
        pos_ok = 0; fault = 0; dir = 0; cur_step = 0; errs = 0;
        clear_speed();
        bound = 0; progress = 0; angle_out = 0; angle_raw = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] val);
        case (idx)
            hsase_pkg::REG_PHASE: phase_ofs = val[15:0];
            hsase_pkg::REG_MOUNT: mount_ofs = val[15:0];
            hsase_pkg::REG_SPAN:  span = val[14:0];
            hsase_pkg::REG_TPP:   tpp = val[15:0];
            hsase_pkg::REG_ERPM:  erpm_k = val;
            hsase_pkg::REG_POLES: poles = val[6:0];
            default: ;
        endcase
    endfunction

    function void clear_speed();
        spd_ok = 0; step_pwm = 0; erpm = 0; mrpm = 0;
        foreach (samples[i]) samples[i] = 0;
        sample_sum = 0; wr_ptr = 0; fill = 0; avg = 0;
    endfunction

    function bit is_ccw();
        return dir == 2;
    endfunction

    function logic [2:0] code_step(logic [2:0] c);
        case (c)
            3'd1: return 6; 3'd2: return 2; 3'd3: return 1;
            3'd4: return 4; 3'd5: return 5; 3'd6: return 3;
            default: return 0;
        endcase
    endfunction

    function logic [15:0] entry_angle(logic [2:0] c, bit ccw);
        case (c)
            3'd1: return ccw ? 16'd30629 : 16'd24357;
            3'd2: return ccw ? 16'd52296 : 16'd46616;
            3'd3: return ccw ? 16'd43170 : 16'd33437;
            3'd4: return ccw ? 16'd8718  : 16'd2535;
            3'd5: return ccw ? 16'd21077 : 16'd11956;
            3'd6: return ccw ? 16'd65216 : 16'd55191;
            default: return 0;
        endcase
    endfunction

    function logic [15:0] mid_angle(logic [2:0] c);
        case (c)
            3'd1: return 16'd27493; 3'd2: return 16'd49456; 3'd3: return 16'd38303;
            3'd4: return 16'd5626;  3'd5: return 16'd16516; 3'd6: return 16'd60167;
            default: return 0;
        endcase
    endfunction

    function void rebuild_angle();
        logic [15:0] a;
        a = is_ccw() ? bound - progress : bound + progress;
        a = a + phase_ofs;
        angle_raw = a;
        angle_out = a + mount_ofs;
    endfunction

    function void snap(logic [2:0] c);
        bound = entry_angle(c, is_ccw());
        if (!spd_ok || step_pwm <= 16'd10) bound = mid_angle(c);
        progress = 0;
        rebuild_angle();
    endfunction

    function void bump();
        if (errs != 8'hFF) errs++;
    endfunction

    function void recompute_speed();
        logic [31:0] q, mag, mmag, pp;
        if (avg == 0)
        begin
            step_pwm = 0; erpm = 0; mrpm = 0;
            return;
        end
        q = (32'(span) * 32'(tpp)) / 32'(avg);
        step_pwm = (q > 32'(span)) ? 16'(span) : q[15:0];
        mag = 32'(erpm_k) / 32'(avg);
        pp = (poles == 0) ? 1 : 32'(poles);
        mmag = mag / pp;
        erpm = is_ccw() ? mag : -mag;
        mrpm = is_ccw() ? mmag : -mmag;
    endfunction

    function void edge_event(logic [2:0] c, logic [23:0] per);
        logic [2:0] st;
        st = code_step(c);
        if (st == 0)
        begin
            pos_ok = 0;
            bump();
            clear_speed();
            if (errs >= 3) fault = 1;
            return;
        end
        if (!pos_ok) dir = is_ccw() ? 2 : 1;
        else if (cur_step != 0 && cur_step != st && (cur_step % 6) + 1 == st) dir = 1;
        else if (cur_step != 0 && cur_step != st && (st % 6) + 1 == cur_step) dir = 2;
        else bump();
        cur_step = st;
        pos_ok = 1;
        if (per != 0)
        begin
            if (fill < 8) fill++;
            else sample_sum -= samples[wr_ptr];
            samples[wr_ptr] = per;
            sample_sum += per;
            wr_ptr = (wr_ptr + 1) % 8;
            avg = sample_sum / fill;
            spd_ok = 1;
            recompute_speed();
        end
        snap(c);
    endfunction

    function void tick_event(logic [2:0] c);
        logic [31:0] nxt;
        if (!pos_ok)
        begin
            if (code_step(c) == 0) return;
            cur_step = code_step(c);
            dir = is_ccw() ? 2 : 1;
            pos_ok = 1;
            snap(c);
            return;
        end
        if (!spd_ok || step_pwm == 0)
        begin
            rebuild_angle();
            return;
        end
        nxt = 32'(progress) + 32'(step_pwm);
        if (nxt >= 32'(span)) nxt = 32'(span);
        progress = nxt[15:0];
        rebuild_angle();
    endfunction

    function void note_input(logic [31:0] beat);
        case (beat[1:0])
            hsase_pkg::FUNC_EDGE:    edge_event(beat[4:2], beat[28:5]);
            hsase_pkg::FUNC_TIMEOUT: clear_speed();
            hsase_pkg::FUNC_TICK:    tick_event(beat[4:2]);
            default: ;
        endcase
        pending_results.push_back({errs, fault, pos_ok, spd_ok, (dir == 2),
                                   avg, step_pwm[14:0], mrpm, erpm, angle_raw, angle_out});
    endfunction

    function void report(string field, logic [31:0] got, logic [31:0] exp_v);
        $display("mismatch %s: got %0h expected %0h", field, got, exp_v);
        mismatches++;
    endfunction

    function void check_result(logic [151:0] got);
        logic [146:0] e;
        if (pending_results.size() == 0)
        begin
            report("unexpected result beat", 32'd1, 32'd0);
            return;
        end
        e = pending_results.pop_front();
        if (got[15:0] !== e[15:0]) report("elec_angle", got[15:0], e[15:0]);
        if (got[31:16] !== e[31:16]) report("angle_before_mount", got[31:16], e[31:16]);
        if (got[63:32] !== e[63:32]) report("elec_rpm", got[63:32], e[63:32]);
        if (got[95:64] !== e[95:64]) report("mech_rpm", got[95:64], e[95:64]);
        if (got[110:96] !== e[110:96]) report("angle_step", got[110:96], e[110:96]);
        if (got[134:111] !== e[134:111]) report("period_average", got[134:111], e[134:111]);
        if (got[135] !== e[135]) report("direction_ccw", got[135], e[135]);
        if (got[136] !== e[136]) report("speed_ok", got[136], e[136]);
        if (got[137] !== e[137]) report("position_ok", got[137], e[137]);
        if (got[138] !== e[138]) report("fault_flag", got[138], e[138]);
        if (got[146:139] !== e[146:139]) report("error_total", got[146:139], e[146:139]);
    endfunction
endclass

module tb_top;
    import hsase_pkg::*;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [151:0] m_tdata;
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = 0;
    logic [30:0]  cfg_data = 0;

    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  recv_hold = 0;
    int  quiet_cycles = 0;
    bit  stim_done = 0;
    hall_scoreboard sb;

    hall_sector_angle_speed_estimator_top DUT (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) sb.note_input(s_tdata);
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > 20000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver
    always @(negedge clk)
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    // valid stays high between beats; it drops while idling and in drain
    task automatic send_beat(logic [1:0] fn, logic [2:0] code, logic [23:0] per);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tdata <= {3'b0, per, code, fn};
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    logic [2:0] cw_code[6] = '{3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1};

    // mostly a rotating motor: edges in order, ticks between, rare noise
    task automatic spin_burst(int n);
        int pos, k;
        bit ccw;
        logic [23:0] per;
        pos = $urandom_range(5);
        ccw = 1'($urandom_range(1));
        per = 24'($urandom_range(40000, 200));
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 30)
            begin
                pos = ccw ? (pos + 5) % 6 : (pos + 1) % 6;
                if ($urandom_range(9) == 0) per = 24'($urandom);
                else if ($urandom_range(9) == 0) per = 0;
                else per = per + 24'($urandom_range(200)) - 24'd100;
                send_beat(FUNC_EDGE, cw_code[pos], per);
            end
            else if (k < 85) send_beat(FUNC_TICK, 3'($urandom), 24'($urandom));
            else if (k < 88) send_beat(FUNC_TIMEOUT, 3'($urandom), 24'($urandom));
            else if (k < 91) send_beat(2'd3, 3'($urandom), 24'($urandom));
            else if (k < 95) send_beat(FUNC_EDGE, 3'($urandom), 24'($urandom));
            else
            begin
                ccw = !ccw;
                send_beat(FUNC_EDGE, cw_code[pos], per);
            end
        end
    endtask

    task automatic random_config();
        write_reg(REG_PHASE, 31'($urandom));
        write_reg(REG_MOUNT, 31'($urandom));
        write_reg(REG_SPAN, 31'($urandom_range(32767, 1)));
        write_reg(REG_TPP, 31'($urandom_range(65535, 1)));
        write_reg(REG_ERPM, 31'($urandom_range(32'h7FFFFFFF, 1)));
        write_reg(REG_POLES, 31'($urandom_range(64, 1)));
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        recv_idle_pct = 58; send_idle_pct = 12;

        // directed: sync by tick, full CW then CCW turn, errors, extremes
        send_beat(FUNC_TICK, 3'd0, 24'd0);
        send_beat(FUNC_TICK, 3'd3, 24'hFFFFFF);
        for (int i = 1; i < 6; i++) send_beat(FUNC_EDGE, cw_code[i], 24'd600);
        send_beat(FUNC_TICK, 3'd7, 24'd0);
        send_beat(FUNC_TICK, 3'd7, 24'd0);
        for (int i = 4; i >= 0; i--) send_beat(FUNC_EDGE, cw_code[i], 24'd1);
        send_beat(FUNC_EDGE, cw_code[0], 24'd0);
        send_beat(FUNC_EDGE, cw_code[2], 24'hFFFFFF);
        send_beat(FUNC_TIMEOUT, 3'd7, 24'hFFFFFF);
        send_beat(2'd3, 3'd7, 24'hFFFFFF);
        send_beat(FUNC_EDGE, 3'd0, 24'd5);
        send_beat(FUNC_EDGE, 3'd7, 24'd5);
        send_beat(FUNC_EDGE, 3'd0, 24'd5);
        send_beat(FUNC_TICK, 3'd7, 24'd0);
        drain();

        // extremes of configuration
        write_reg(REG_PHASE, 31'hFFFF); write_reg(REG_MOUNT, 31'd0);
        write_reg(REG_SPAN, 31'h7FFF); write_reg(REG_TPP, 31'hFFFF);
        write_reg(REG_ERPM, 31'h7FFFFFFF); write_reg(REG_POLES, 31'd0);
        spin_burst(150);
        drain();
        write_reg(REG_SPAN, 31'd1); write_reg(REG_TPP, 31'd1);
        write_reg(REG_ERPM, 31'd1); write_reg(REG_POLES, 31'd64);
        spin_burst(100);

        // long receiver stall while sender keeps offering
        recv_hold = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                recv_hold = 0;
            end
            spin_burst(20);
        join
        drain();

        recv_idle_pct = 12; send_idle_pct = 58;
        random_config();
        spin_burst(250);
        drain();
        for (int i = 0; i < 3; i++)
        begin
            if (i == 1)
            begin
                recv_idle_pct = 0; send_idle_pct = 0;
            end
            random_config();
            spin_burst(150);
            drain();
        end
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
